// File: hdl/kmgd_pkg.sv
// ----------------------------------------------------------------------------
// kmgd_pkg
// Types, codes and helpers shared by the key matrix debounce block.
// ----------------------------------------------------------------------------
`default_nettype none

package kmgd_pkg;

    localparam int ROW_W        = 3;
    localparam int COL_W        = 16;
    localparam int KEY_W        = 8;
    localparam int CD_W         = 8;
    localparam int WCNT_W       = 7;
    localparam int POP_W        = 5;
    localparam int WAKE_PERIOD  = 70;

    localparam logic [WCNT_W-1:0] WCNT_LAST = WCNT_W'(WAKE_PERIOD - 1);

    // request codes
    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_READ   = 2'd1,
        REQ_ARM    = 2'd2,
        REQ_LINK   = 2'd3
    } req_code_t;

    typedef struct packed {
        req_code_t          req_type;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   cols;
        logic               last_row;
    } req_t;

    typedef struct packed {
        logic [COL_W-1:0]   row_bits;
        logic               from_wakeup;
        logic               settled;
        logic               committed;
        logic [KEY_W-1:0]   key_count;
    } rsp_t;

    // control from the sequencing logic to the matrix store
    typedef struct packed {
        logic               sample_en;
        logic               commit;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   cols;
    } mtx_ctrl_t;

    // status from the matrix store
    typedef struct packed {
        logic               changed;
        logic               any_nz;
        logic [ROW_W-1:0]   first_row;
        logic [COL_W-1:0]   first_cols;
        logic [COL_W-1:0]   read_bits;
        logic [KEY_W-1:0]   key_count;
    } mtx_stat_t;

    function automatic logic [POP_W-1:0] popcount16(input logic [COL_W-1:0] v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int i = 0; i < COL_W; i++)
        begin
            n = n + POP_W'(v[i]);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// File: hdl/kmgd_matrix.sv
// ----------------------------------------------------------------------------
// kmgd_matrix
// Sample and stable row stores with running closed-key counts.
// ----------------------------------------------------------------------------
`default_nettype none

module kmgd_matrix #(
    parameter int ROWS = 8,
    parameter int COLS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire kmgd_pkg::mtx_ctrl_t  ctrl,
    output kmgd_pkg::mtx_stat_t       stat
);

    localparam int CNT_W = $clog2(ROWS * COLS + 1);

    logic [COLS-1:0]  sample_reg [ROWS];
    logic [COLS-1:0]  sample_next [ROWS];
    logic [COLS-1:0]  stable_reg [ROWS];
    logic [CNT_W-1:0] sample_cnt_reg;
    logic [CNT_W-1:0] sample_cnt_next;
    logic [CNT_W-1:0] stable_cnt_reg;
    logic [CNT_W-1:0] stable_cnt_new;
    logic [COLS-1:0]  old_bits;
    logic [COLS-1:0]  new_bits;
    logic [kmgd_pkg::POP_W-1:0] pop_old;
    logic [kmgd_pkg::POP_W-1:0] pop_new;
    logic                       changed;
    logic                       any_nz;
    logic [kmgd_pkg::ROW_W-1:0] first_row;
    logic [kmgd_pkg::COL_W-1:0] first_cols;
    logic [kmgd_pkg::COL_W-1:0] read_bits;
    logic [kmgd_pkg::KEY_W-1:0] key_count;

    assign new_bits = ctrl.cols[COLS-1:0];

    assign stat = {changed, any_nz, first_row, first_cols, read_bits, key_count};

    always_comb
    begin
        changed  = 1'b0;
        old_bits = '0;
        for (int i = 0; i < ROWS; i++)
        begin
            sample_next[i] = sample_reg[i];
            if (ctrl.sample_en && (32'(ctrl.row) == i) && (sample_reg[i] != new_bits))
            begin
                changed        = 1'b1;
                old_bits       = sample_reg[i];
                sample_next[i] = new_bits;
            end
        end
    end

    // running count follows the one row that changed
    assign pop_old = kmgd_pkg::popcount16(kmgd_pkg::COL_W'(old_bits));
    assign pop_new = kmgd_pkg::popcount16(kmgd_pkg::COL_W'(new_bits));
    assign sample_cnt_next = changed
                           ? (sample_cnt_reg - CNT_W'(pop_old) + CNT_W'(pop_new))
                           : sample_cnt_reg;

    // first nonzero row of the updated samples
    always_comb
    begin
        any_nz     = 1'b0;
        first_row  = '0;
        first_cols = '0;
        for (int i = ROWS - 1; i >= 0; i--)
        begin
            if (|sample_next[i])
            begin
                any_nz     = 1'b1;
                first_row  = kmgd_pkg::ROW_W'(i);
                first_cols = kmgd_pkg::COL_W'(sample_next[i]);
            end
        end
    end

    always_comb
    begin
        read_bits = '0;
        for (int i = 0; i < ROWS; i++)
        begin
            if (32'(ctrl.row) == i)
            begin
                read_bits = kmgd_pkg::COL_W'(stable_reg[i]);
            end
        end
    end

    // key count after this item, saturated
    assign stable_cnt_new = ctrl.commit ? sample_cnt_next : stable_cnt_reg;
    assign key_count = (int'(stable_cnt_new) > 255) ? 8'hFF
                                                     : kmgd_pkg::KEY_W'(stable_cnt_new);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                sample_reg[i] <= '0;
                stable_reg[i] <= '0;
            end
            sample_cnt_reg <= '0;
            stable_cnt_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                sample_reg[i] <= sample_next[i];
                if (ctrl.commit)
                begin
                    stable_reg[i] <= sample_next[i];
                end
            end
            sample_cnt_reg <= sample_cnt_next;
            stable_cnt_reg <= stable_cnt_new;
        end
    end

endmodule

`default_nettype wire

// File: hdl/key_matrix_global_debounce.sv
// ----------------------------------------------------------------------------
// key_matrix_global_debounce
// Key matrix debouncer with one quiet countdown shared by all rows.
// ----------------------------------------------------------------------------
// pipeline: an accepted item is held in the input register, then its result
//   item in the result register; a stall on rsp_ready can hold either one
// throughput: one item per cycle while rsp_ready keeps up; the result and input
//   registers each move whenever the stage after them is free or taken that cycle
// reset: rst_n clears all control state, both row stores and the countdown at
//   once, sets wakeup row and columns to all ones; reload reads 1 until written
`default_nettype none

module key_matrix_global_debounce #(
    parameter int ROWS = 8,
    parameter int COLS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration
    input  wire logic                           cfg_wr_en,
    input  wire logic [kmgd_pkg::CD_W-1:0]      cfg_wr_data,
    // request channel
    input  wire logic                           req_valid,
    output logic                                req_ready,
    input  wire kmgd_pkg::req_t                 req,
    // response channel
    output logic                                rsp_valid,
    input  wire logic                           rsp_ready,
    output kmgd_pkg::rsp_t                      rsp
);

    // pipeline registers
    logic                           stage_valid_reg;
    kmgd_pkg::req_t                 stage_item_reg;
    logic                           rsp_valid_reg;
    kmgd_pkg::rsp_t                 rsp_reg;
    kmgd_pkg::rsp_t                 rsp_next;
    logic                           advance;
    logic                           fire;

    // debounce and wakeup state
    logic [kmgd_pkg::CD_W-1:0]      reload_reg;
    logic [kmgd_pkg::CD_W-1:0]      countdown_reg;
    logic [kmgd_pkg::CD_W-1:0]      countdown_next;
    logic [kmgd_pkg::CD_W-1:0]      countdown_mid;
    logic [kmgd_pkg::CD_W-1:0]      reload_eff;
    logic                           wk_active_reg;
    logic                           wk_active_next;
    logic                           wk_first_reg;
    logic                           wk_first_next;
    logic [kmgd_pkg::ROW_W-1:0]     wk_row_reg;
    logic [kmgd_pkg::ROW_W-1:0]     wk_row_next;
    logic [kmgd_pkg::COL_W-1:0]     wk_cols_reg;
    logic [kmgd_pkg::COL_W-1:0]     wk_cols_next;
    logic                           link_up_reg;
    logic                           link_up_next;
    logic [kmgd_pkg::WCNT_W-1:0]    wk_cnt_reg;
    logic [kmgd_pkg::WCNT_W-1:0]    wk_cnt_next;

    kmgd_pkg::mtx_ctrl_t            mtx_ctrl;
    kmgd_pkg::mtx_stat_t            mtx_stat;

    // handshake: the result register frees itself when taken, the input
    // register moves on whenever the result register can accept
    assign advance   = !rsp_valid_reg || rsp_ready;
    assign fire      = stage_valid_reg && advance;
    assign req_ready = !stage_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // a reload of zero behaves as one
    assign reload_eff = (reload_reg == '0) ? kmgd_pkg::CD_W'(1) : reload_reg;

    // any change to a row restarts the shared countdown, at one while in wakeup mode
    assign countdown_mid = mtx_stat.changed
                         ? (wk_active_reg ? kmgd_pkg::CD_W'(1) : reload_eff)
                         : countdown_reg;

    always_comb
    begin
        mtx_ctrl.sample_en = fire && (stage_item_reg.req_type == kmgd_pkg::REQ_SAMPLE);
        mtx_ctrl.commit    = 1'b0;
        mtx_ctrl.row       = stage_item_reg.row;
        mtx_ctrl.cols      = stage_item_reg.cols;

        countdown_next = countdown_reg;
        wk_active_next = wk_active_reg;
        wk_first_next  = wk_first_reg;
        wk_row_next    = wk_row_reg;
        wk_cols_next   = wk_cols_reg;
        link_up_next   = link_up_reg;
        wk_cnt_next    = wk_cnt_reg;

        rsp_next.row_bits    = '0;
        rsp_next.from_wakeup = 1'b0;

        if (fire)
        begin
            unique case (stage_item_reg.req_type)
                kmgd_pkg::REQ_SAMPLE:
                begin
                    countdown_next = countdown_mid;
                    if (stage_item_reg.last_row)
                    begin
                        // scan end: step the countdown, commit on reaching zero
                        if (countdown_mid != '0)
                        begin
                            countdown_next = countdown_mid - kmgd_pkg::CD_W'(1);
                            if (countdown_mid == kmgd_pkg::CD_W'(1))
                            begin
                                mtx_ctrl.commit = 1'b1;
                                // wakeup captures the first nonzero committed row
                                if (wk_active_reg && mtx_stat.any_nz)
                                begin
                                    wk_row_next  = mtx_stat.first_row;
                                    wk_cols_next = mtx_stat.first_cols;
                                end
                            end
                        end
                        // first scan after arming: nothing pressed ends wakeup mode
                        if (wk_first_reg)
                        begin
                            wk_first_next = 1'b0;
                            if (wk_cols_next == '0)
                            begin
                                wk_active_next = 1'b0;
                            end
                        end
                    end
                end
                kmgd_pkg::REQ_READ:
                begin
                    rsp_next.row_bits = mtx_stat.read_bits;
                    if ((stage_item_reg.row == wk_row_reg) && wk_active_reg && link_up_reg)
                    begin
                        // reads of the wakeup row count modulo the wakeup period
                        if (wk_cnt_reg == kmgd_pkg::WCNT_LAST)
                        begin
                            wk_cnt_next          = '0;
                            wk_active_next       = 1'b0;
                            rsp_next.row_bits    = wk_cols_reg;
                            rsp_next.from_wakeup = 1'b1;
                        end
                        else
                        begin
                            wk_cnt_next = wk_cnt_reg + kmgd_pkg::WCNT_W'(1);
                        end
                    end
                end
                kmgd_pkg::REQ_ARM:
                begin
                    wk_active_next = 1'b1;
                    wk_first_next  = 1'b1;
                    wk_row_next    = '0;
                    wk_cols_next   = '0;
                end
                kmgd_pkg::REQ_LINK:
                begin
                    link_up_next = 1'b1;
                end
                default:
                begin
                    link_up_next = link_up_reg;
                end
            endcase
        end

        rsp_next.settled   = (countdown_next == '0);
        rsp_next.committed = mtx_ctrl.commit;
        rsp_next.key_count = mtx_stat.key_count;
    end

    // sample and stable row stores
    kmgd_matrix #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_matrix (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mtx_ctrl),
        .stat  (mtx_stat)
    );

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            reload_reg      <= kmgd_pkg::CD_W'(1);
            countdown_reg   <= '0;
            wk_active_reg   <= 1'b0;
            wk_first_reg    <= 1'b0;
            wk_row_reg      <= '1;
            wk_cols_reg     <= '1;
            link_up_reg     <= 1'b0;
            wk_cnt_reg      <= '0;
        end
        else
        begin
            if (req_ready)
            begin
                stage_valid_reg <= req_valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= stage_valid_reg;
            end
            if (cfg_wr_en)
            begin
                reload_reg <= cfg_wr_data;
            end
            countdown_reg <= countdown_next;
            wk_active_reg <= wk_active_next;
            wk_first_reg  <= wk_first_next;
            wk_row_reg    <= wk_row_next;
            wk_cols_reg   <= wk_cols_next;
            link_up_reg   <= link_up_next;
            wk_cnt_reg    <= wk_cnt_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            stage_item_reg <= req;
        end
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

`default_nettype wire
